FILE: hw/rtl/llni_pkg.sv
// Shared constants, types and tables of the lattice link neighbour index block.
package llni_pkg;

  localparam int SIZE_X = 32;
  localparam int SIZE_Y = 32;
  localparam int SIZE_T = 32;

  localparam int LINK_X_W = 5;
  localparam int LINK_Y_W = 5;
  localparam int LINK_T_W = 5;
  localparam int SLOT_W   = 3;
  localparam int NB_W     = 16;
  localparam int CALC_W   = 32;

  localparam int CX_W = $clog2(SIZE_X);
  localparam int CY_W = $clog2(SIZE_Y);
  localparam int CT_W = $clog2(SIZE_T);

  localparam int PLANE = SIZE_X * SIZE_Y;
  localparam int VOL   = PLANE * SIZE_T;

  localparam int SLOTS = 7;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  typedef struct packed {
    logic [1:0] xs;
    logic [1:0] ys;
    logic       tuse;
    logic       ndir;
  } offs_t;

  typedef struct packed {
    logic [CX_W-1:0] x;
    logic [CY_W-1:0] y;
    logic [CT_W-1:0] t;
    logic            dir;
    logic            odd;
  } job_t;

  localparam offs_t OFFS [2][2][SLOTS] = '{
    '{
      '{'{STEP_INC,  STEP_NONE, 1'b0, 1'b1}, '{STEP_NONE, STEP_INC,  1'b0, 1'b0},
        '{STEP_NONE, STEP_NONE, 1'b0, 1'b1}, '{STEP_NONE, STEP_NONE, 1'b1, 1'b0},
        '{STEP_INC,  STEP_NONE, 1'b1, 1'b1}, '{STEP_NONE, STEP_INC,  1'b1, 1'b0},
        '{STEP_NONE, STEP_NONE, 1'b1, 1'b1}},
      '{'{STEP_NONE, STEP_INC,  1'b0, 1'b0}, '{STEP_INC,  STEP_NONE, 1'b0, 1'b1},
        '{STEP_NONE, STEP_NONE, 1'b0, 1'b0}, '{STEP_NONE, STEP_NONE, 1'b1, 1'b1},
        '{STEP_NONE, STEP_INC,  1'b1, 1'b0}, '{STEP_INC,  STEP_NONE, 1'b1, 1'b1},
        '{STEP_NONE, STEP_NONE, 1'b1, 1'b0}}
    },
    '{
      '{'{STEP_NONE, STEP_DEC,  1'b0, 1'b1}, '{STEP_NONE, STEP_DEC,  1'b0, 1'b0},
        '{STEP_INC,  STEP_DEC,  1'b0, 1'b1}, '{STEP_NONE, STEP_NONE, 1'b1, 1'b0},
        '{STEP_NONE, STEP_DEC,  1'b1, 1'b1}, '{STEP_NONE, STEP_DEC,  1'b1, 1'b0},
        '{STEP_INC,  STEP_DEC,  1'b1, 1'b1}},
      '{'{STEP_DEC,  STEP_NONE, 1'b0, 1'b0}, '{STEP_DEC,  STEP_NONE, 1'b0, 1'b1},
        '{STEP_DEC,  STEP_INC,  1'b0, 1'b0}, '{STEP_NONE, STEP_NONE, 1'b1, 1'b1},
        '{STEP_DEC,  STEP_NONE, 1'b1, 1'b0}, '{STEP_DEC,  STEP_NONE, 1'b1, 1'b1},
        '{STEP_DEC,  STEP_INC,  1'b1, 1'b0}}
    }
  };

  function automatic logic [CX_W-1:0] reduce_x(input logic [LINK_X_W-1:0] v);
    logic [CX_W-1:0] r;
    r = '0;
    for (int i = 0; i < 2**LINK_X_W; i++) begin
      if (v == LINK_X_W'(i)) r = CX_W'(i % SIZE_X);
    end
    return r;
  endfunction

  function automatic logic [CY_W-1:0] reduce_y(input logic [LINK_Y_W-1:0] v);
    logic [CY_W-1:0] r;
    r = '0;
    for (int i = 0; i < 2**LINK_Y_W; i++) begin
      if (v == LINK_Y_W'(i)) r = CY_W'(i % SIZE_Y);
    end
    return r;
  endfunction

  function automatic logic [CT_W-1:0] reduce_t(input logic [LINK_T_W-1:0] v);
    logic [CT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 2**LINK_T_W; i++) begin
      if (v == LINK_T_W'(i)) r = CT_W'(i % SIZE_T);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/llni_if.sv
// Valid/ready channel interfaces for link input and neighbour output transactions.
interface llni_in_if
  import llni_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LINK_X_W-1:0] link_x;
  logic [LINK_Y_W-1:0] link_y;
  logic [LINK_T_W-1:0] link_t;
  logic                link_dir;

  modport source (output valid, output link_x, output link_y, output link_t,
                  output link_dir, input ready);
  modport sink   (input valid, input link_x, input link_y, input link_t,
                  input link_dir, output ready);
endinterface

interface llni_out_if
  import llni_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              backward;
  logic [NB_W-1:0]   neighbour_link;
  logic              last;

  modport source (output valid, output slot, output backward, output neighbour_link,
                  output last, input ready);
  modport sink   (input valid, input slot, input backward, input neighbour_link,
                  input last, output ready);
endinterface

FILE: hw/rtl/lattice_link_neighbour_index.sv
// Top level: emits the fourteen neighbour link indices of each input link.
// The input link is captured in the job register; its first result is then registered at the output.
// A slot sequencer gives one result per cycle while the output is not stalled.
// The next link is accepted in the cycle its fourteenth result enters the output register.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
module lattice_link_neighbour_index
  import llni_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  llni_in_if.sink    in_ch,
  llni_out_if.source out_ch
);

  logic              busy_r, busy_nxt;
  job_t              job_r, job_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              bw_r, bw_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_bw_r;
  logic [NB_W-1:0]   out_nb_r;
  logic              out_last_r;

  logic              advance;
  logic              seq_last;
  logic              in_take;
  logic [NB_W-1:0]   nb_calc;
  job_t              job_in;

  llni_slot_calc u_calc (
    .job            (job_r),
    .slot           (slot_r),
    .backward       (bw_r),
    .neighbour_link (nb_calc)
  );

  assign seq_last = bw_r && (slot_r == SLOT_LAST);
  assign advance  = busy_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy_r || (advance && seq_last);
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    job_in.x   = reduce_x(in_ch.link_x);
    job_in.y   = reduce_y(in_ch.link_y);
    job_in.t   = reduce_t(in_ch.link_t);
    job_in.dir = in_ch.link_dir;
    job_in.odd = job_in.x[0] ^ job_in.y[0] ^ job_in.t[0];
  end

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    slot_nxt = slot_r;
    bw_nxt   = bw_r;
    if (advance) begin
      if (seq_last) begin
        busy_nxt = 1'b0;
      end else if (slot_r == SLOT_LAST) begin
        slot_nxt = '0;
        bw_nxt   = 1'b1;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
    if (in_take) begin
      busy_nxt = 1'b1;
      job_nxt  = job_in;
      slot_nxt = '0;
      bw_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= '0;
      bw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      slot_r      <= slot_nxt;
      bw_r        <= bw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (advance) begin
      out_slot_r <= slot_r;
      out_bw_r   <= bw_r;
      out_nb_r   <= nb_calc;
      out_last_r <= seq_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.backward       = out_bw_r;
  assign out_ch.neighbour_link = out_nb_r;
  assign out_ch.last           = out_last_r;

endmodule

FILE: hw/rtl/llni_slot_calc.sv
// Combinational neighbour index for one slot of the current link.
module llni_slot_calc
  import llni_pkg::*;
(
  input  job_t              job,
  input  logic [SLOT_W-1:0] slot,
  input  logic              backward,
  output logic [NB_W-1:0]   neighbour_link
);

  offs_t           ent;
  logic [CX_W-1:0] nx;
  logic [CY_W-1:0] ny;
  logic [CT_W-1:0] nt;
  logic [CALC_W-1:0] idx;

  always_comb begin
    ent = OFFS[backward ^ job.odd][job.dir][slot];

    case (ent.xs)
      STEP_INC: nx = (job.x == CX_W'(SIZE_X - 1)) ? '0 : job.x + CX_W'(1);
      STEP_DEC: nx = (job.x == '0) ? CX_W'(SIZE_X - 1) : job.x - CX_W'(1);
      default:  nx = job.x;
    endcase

    case (ent.ys)
      STEP_INC: ny = (job.y == CY_W'(SIZE_Y - 1)) ? '0 : job.y + CY_W'(1);
      STEP_DEC: ny = (job.y == '0) ? CY_W'(SIZE_Y - 1) : job.y - CY_W'(1);
      default:  ny = job.y;
    endcase

    if (!ent.tuse) begin
      nt = job.t;
    end else if (!backward) begin
      nt = (job.t == CT_W'(SIZE_T - 1)) ? '0 : job.t + CT_W'(1);
    end else begin
      nt = (job.t == '0) ? CT_W'(SIZE_T - 1) : job.t - CT_W'(1);
    end

    idx = (ent.ndir ? CALC_W'(VOL) : '0)
        + CALC_W'(nt) * CALC_W'(PLANE)
        + CALC_W'(ny) * CALC_W'(SIZE_X)
        + CALC_W'(nx);
    neighbour_link = idx[NB_W-1:0];
  end

endmodule

FILE: hw/rtl/llni_checker.sv
// Port-level assertions for the neighbour index block and their bind.
module llni_checker
  import llni_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_backward,
  input logic [NB_W-1:0]   out_nb,
  input logic              out_last
);

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_backward)
      && $stable(out_nb) && $stable(out_last))
    else $error("output transaction changed while stalled");

  // After a link is taken, the next one waits for the remaining results.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a transaction");

  // Last marks exactly backward slot six.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_backward && out_slot == SLOT_LAST)))
    else $error("last flag does not match the final slot");

  // Slot numbers stay within the set.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_slot <= SLOT_LAST)
    else $error("slot number out of range");

endmodule

bind lattice_link_neighbour_index llni_checker u_llni_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_slot     (out_ch.slot),
  .out_backward (out_ch.backward),
  .out_nb       (out_ch.neighbour_link),
  .out_last     (out_ch.last)
);

FILE: bench/neighbour_index_checker.sv
// Checker that predicts the fourteen neighbor link indices of each link and compares them.
`timescale 1ns / 1ps

module neighbour_index_checker
  import llni_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  llni_in_if         in_mon,
  llni_out_if        out_mon,
  output int         mismatch_count,
  output int         outstanding
);

  localparam logic [1:0] NO = STEP_NONE;
  localparam logic [1:0] UP = STEP_INC;
  localparam logic [1:0] DN = STEP_DEC;

  // Indexed by offset set, link direction and slot. Set 0 is the forward set at even parity.
  localparam offs_t NEIGHBOUR_STEPS [2][2][SLOTS] = '{
    '{
      '{'{UP, NO, 1'b0, 1'b1}, '{NO, UP, 1'b0, 1'b0}, '{NO, NO, 1'b0, 1'b1},
        '{NO, NO, 1'b1, 1'b0}, '{UP, NO, 1'b1, 1'b1}, '{NO, UP, 1'b1, 1'b0},
        '{NO, NO, 1'b1, 1'b1}},
      '{'{NO, UP, 1'b0, 1'b0}, '{UP, NO, 1'b0, 1'b1}, '{NO, NO, 1'b0, 1'b0},
        '{NO, NO, 1'b1, 1'b1}, '{NO, UP, 1'b1, 1'b0}, '{UP, NO, 1'b1, 1'b1},
        '{NO, NO, 1'b1, 1'b0}}
    },
    '{
      '{'{NO, DN, 1'b0, 1'b1}, '{NO, DN, 1'b0, 1'b0}, '{UP, DN, 1'b0, 1'b1},
        '{NO, NO, 1'b1, 1'b0}, '{NO, DN, 1'b1, 1'b1}, '{NO, DN, 1'b1, 1'b0},
        '{UP, DN, 1'b1, 1'b1}},
      '{'{DN, NO, 1'b0, 1'b0}, '{DN, NO, 1'b0, 1'b1}, '{DN, UP, 1'b0, 1'b0},
        '{NO, NO, 1'b1, 1'b1}, '{DN, NO, 1'b1, 1'b0}, '{DN, NO, 1'b1, 1'b1},
        '{DN, UP, 1'b1, 1'b0}}
    }
  };

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              backward;
    logic [NB_W-1:0]   neighbour_link;
    logic              last;
  } neighbour_t;

  neighbour_t expected_neighbours [$];

  function automatic longint wrap_coord(input longint c, input logic [1:0] step,
                                        input longint size);
    longint r;
    r = c;
    if (step == STEP_INC) r = (c + 1) % size;
    else if (step == STEP_DEC) r = (c + size - 1) % size;
    return r;
  endfunction

  function automatic void queue_neighbours(input logic [LINK_X_W-1:0] lx,
                                           input logic [LINK_Y_W-1:0] ly,
                                           input logic [LINK_T_W-1:0] lt,
                                           input logic ldir);
    longint x, y, t, nx, ny, nt, idx;
    logic odd, set;
    logic [1:0] tstep;
    offs_t step;
    neighbour_t nb;
    x = longint'(lx) % SIZE_X;
    y = longint'(ly) % SIZE_Y;
    t = longint'(lt) % SIZE_T;
    odd = (x + y + t) % 2 == 1;
    for (int bw = 0; bw < 2; bw++) begin
      set = bw[0] ^ odd;
      for (int s = 0; s < SLOTS; s++) begin
        step = NEIGHBOUR_STEPS[set][ldir][SLOT_W'(s)];
        tstep = !step.tuse ? STEP_NONE : (bw == 1 ? STEP_DEC : STEP_INC);
        nx = wrap_coord(x, step.xs, longint'(SIZE_X));
        ny = wrap_coord(y, step.ys, longint'(SIZE_Y));
        nt = wrap_coord(t, tstep, longint'(SIZE_T));
        idx = longint'(step.ndir) * SIZE_X * SIZE_Y * SIZE_T
              + nt * SIZE_X * SIZE_Y + ny * SIZE_X + nx;
        nb.slot = SLOT_W'(s);
        nb.backward = bw[0];
        nb.neighbour_link = NB_W'(idx);
        nb.last = (bw == 1) && (s == SLOTS - 1);
        expected_neighbours.push_back(nb);
      end
    end
  endfunction

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    neighbour_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_neighbours.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected neighbour transaction: slot %0d bw %0b idx %0d last %0b",
                     out_mon.slot, out_mon.backward, out_mon.neighbour_link, out_mon.last);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_neighbours.pop_front();
          if (out_mon.slot !== want.slot || out_mon.backward !== want.backward ||
              out_mon.neighbour_link !== want.neighbour_link ||
              out_mon.last !== want.last) begin
            if (mismatch_count < 10)
              $display("expected slot %0d bw %0b idx %0d last %0b, got %0d %0b %0d %0b",
                       want.slot, want.backward, want.neighbour_link, want.last,
                       out_mon.slot, out_mon.backward, out_mon.neighbour_link,
                       out_mon.last);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        queue_neighbours(in_mon.link_x, in_mon.link_y, in_mon.link_t, in_mon.link_dir);
    end
    outstanding <= expected_neighbours.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the bench: clock, reset, link stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module testbench
  import llni_pkg::*;
();

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   outstanding;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_trigger;

  llni_in_if  in_ch ();
  llni_out_if out_ch ();

  lattice_link_neighbour_index dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  neighbour_index_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #6 clk = ~clk;

  task automatic send_link(input logic [LINK_X_W-1:0] x, input logic [LINK_Y_W-1:0] y,
                           input logic [LINK_T_W-1:0] t, input logic dir);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.link_x   <= x;
    in_ch.link_y   <= y;
    in_ch.link_t   <= t;
    in_ch.link_dir <= dir;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random_links(input int count);
    for (int i = 0; i < count; i++)
      send_link(LINK_X_W'($urandom_range(0, 31)), LINK_Y_W'($urandom_range(0, 31)),
                LINK_T_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: random stalls, plus a long hold-off whenever hold_trigger moves.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.link_x = '0;
    in_ch.link_y = '0;
    in_ch.link_t = '0;
    in_ch.link_dir = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_trigger = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Every corner of the lattice in both directions covers wraparound on each axis
    // and both parities.
    for (int c = 0; c < 16; c++)
      send_link(c[0] ? 5'd31 : 5'd0, c[1] ? 5'd31 : 5'd0, c[2] ? 5'd31 : 5'd0, c[3]);
    send_link(5'd1, 5'd0, 5'd0, 1'b0);
    send_link(5'd5, 5'd17, 5'd30, 1'b1);
    send_link(5'd30, 5'd1, 5'd16, 1'b0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      send_random_links(36);
    end

    // The receiver holds off for a long stretch while links keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_trigger = hold_trigger + 1;
    send_random_links(8);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("lattice_link_neighbour_index: match");
    else
      $display("lattice_link_neighbour_index: mismatch");
    $finish;
  end

  initial begin
    #5000000;
    $display("lattice_link_neighbour_index: mismatch");
    $finish;
  end

endmodule
